// ----- rtl/core/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the multiplexed servo pulse generator.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int CHANNELS = 7;
   localparam int CH_W     = 3;
   localparam int WIDTH_W  = 12;
   localparam int DATA_W   = 10;
   localparam int BYTE_W   = 8;
   localparam int ACTION_W = 2;
   localparam int PINS_W   = 7;
   localparam int ADDR_W   = 4;

   localparam logic [WIDTH_W-1:0] SLOT_RESET   = 12'd2857;
   localparam logic [WIDTH_W-1:0] CENTER_RESET = 12'd1500;
   localparam logic [BYTE_W-1:0]  OFFSET_RESET = 8'd100;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 12'd1500;
   localparam logic [WIDTH_W-1:0] ADC_BASE     = 12'd500;
   localparam logic [WIDTH_W:0]   SERIAL_GAIN  = 13'd15;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 2'd0,
      ACT_SERIAL = 2'd1,
      ACT_ADC    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_SLOT_TICKS    = 2'd0,
      CSR_CENTER_TICKS  = 2'd1,
      CSR_SERIAL_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] slot_ticks;
      logic [WIDTH_W-1:0] center_ticks;
      logic [BYTE_W-1:0]  serial_offset;
   } cfg_type;

endpackage

// ----- rtl/core/msp_csr.sv -----
// ----------------------------------------------------------------------------
// msp_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module msp_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [msp_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output msp_pkg::cfg_type           cfg
);
   import msp_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_SLOT_TICKS:    cfg_in.slot_ticks    = csr_pwdata[WIDTH_W-1:0];
            CSR_CENTER_TICKS:  cfg_in.center_ticks  = csr_pwdata[WIDTH_W-1:0];
            CSR_SERIAL_OFFSET: cfg_in.serial_offset = csr_pwdata[BYTE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_SLOT_TICKS:    csr_prdata = {20'd0, cfg_ff.slot_ticks};
         CSR_CENTER_TICKS:  csr_prdata = {20'd0, cfg_ff.center_ticks};
         CSR_SERIAL_OFFSET: csr_prdata = {24'd0, cfg_ff.serial_offset};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_ticks    <= SLOT_RESET;
         cfg_ff.center_ticks  <= CENTER_RESET;
         cfg_ff.serial_offset <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/msp_width.sv -----
// ----------------------------------------------------------------------------
// msp_width
// Pulse width from a serial command byte or from an ADC sample.
// ----------------------------------------------------------------------------
module msp_width (
   input  logic [msp_pkg::DATA_W-1:0]  data,
   input  logic [msp_pkg::WIDTH_W-1:0] center_ticks,
   input  logic [msp_pkg::BYTE_W-1:0]  serial_offset,
   output logic [msp_pkg::WIDTH_W-1:0] serial_width,
   output logic [msp_pkg::WIDTH_W-1:0] adc_width
);
   import msp_pkg::*;

   logic signed [BYTE_W:0]    diff;
   logic signed [WIDTH_W:0]   prod;
   logic signed [WIDTH_W:0]   biased;
   logic signed [WIDTH_W:0]   half;
   logic signed [WIDTH_W+1:0] wide;

   always_comb begin
      diff   = $signed({1'b0, data[BYTE_W-1:0]}) - $signed({1'b0, serial_offset});
      prod   = $signed({{(WIDTH_W-BYTE_W){diff[BYTE_W]}}, diff}) * $signed(SERIAL_GAIN);
      // round toward zero on the halving
      biased = prod + $signed({{WIDTH_W{1'b0}}, prod[WIDTH_W]});
      half   = biased >>> 1;
      wide   = $signed({2'b00, center_ticks}) + $signed({half[WIDTH_W], half});
      if (wide[WIDTH_W+1]) begin
         serial_width = '0;
      end else if (wide[WIDTH_W]) begin
         serial_width = '1;
      end else begin
         serial_width = wide[WIDTH_W-1:0];
      end
      adc_width = {1'b0, data, 1'b0} + ADC_BASE;
   end

endmodule

// ----- rtl/core/multiplexed_servo_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_generator
// Seven-channel servo pulse generator, one channel driven per slot.
// ----------------------------------------------------------------------------
// Every request word (tick, serial byte or ADC sample) yields exactly one
// response word with the pin levels and the next requested channel. Words
// go through an input register and a result register; one word is taken
// every clock cycle as long as the response side keeps up. Channel widths
// live in flip-flops and are reset to 1500 ticks; configuration is read
// and written over the csr_ port, which never waits.
module multiplexed_servo_pulse_generator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // data[9:0], adc_channel[12:10], zero
   input  logic [1:0]                 req_tuser,   // action[1:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // servo_pins[6:0], request_channel[9:7], zero
   output logic [0:0]                 rsp_tuser,   // request_valid[0]
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [msp_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import msp_pkg::*;

   cfg_type cfg;

   // input register
   logic                in_valid_ff;
   logic [ACTION_W-1:0] in_action_ff;
   logic [DATA_W-1:0]   in_data_ff;
   logic [CH_W-1:0]     in_adc_ch_ff;

   // block state
   logic [WIDTH_W-1:0] width_ff [CHANNELS];
   logic [WIDTH_W-1:0] width_in [CHANNELS];
   logic [CH_W-1:0]    active_ff, active_in;
   logic [WIDTH_W-1:0] slot_ff, slot_in;
   logic               manual_ff, manual_in;
   logic [CH_W-1:0]    serial_ch_ff, serial_ch_in;

   // result register
   logic              rsp_valid_ff;
   logic [PINS_W-1:0] rsp_pins_ff, rsp_pins_in;
   logic              rsp_req_valid_ff, rsp_req_valid_in;
   logic [CH_W-1:0]   rsp_req_ch_ff, rsp_req_ch_in;

   logic               out_ready;
   logic               advance;
   logic [WIDTH_W-1:0] serial_width;
   logic [WIDTH_W-1:0] adc_width;
   logic [WIDTH_W-1:0] slot_inc;

   msp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msp_width u_width (
      .data          (in_data_ff),
      .center_ticks  (cfg.center_ticks),
      .serial_offset (cfg.serial_offset),
      .serial_width  (serial_width),
      .adc_width     (adc_width)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;
   assign advance    = in_valid_ff && out_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-PINS_W-CH_W){1'b0}}, rsp_req_ch_ff, rsp_pins_ff};
   assign rsp_tuser  = rsp_req_valid_ff;

   always_comb begin
      width_in         = width_ff;
      active_in        = active_ff;
      slot_in          = slot_ff;
      manual_in        = manual_ff;
      serial_ch_in     = serial_ch_ff;
      rsp_req_valid_in = 1'b0;
      slot_inc         = slot_ff + 1'b1;

      case (action_type'(in_action_ff))
         ACT_TICK: begin
            if (slot_inc >= cfg.slot_ticks || slot_inc == '0) begin
               slot_in   = '0;
               active_in = (active_ff == CH_W'(CHANNELS - 1)) ? '0 : active_ff + 1'b1;
            end else begin
               slot_in = slot_inc;
            end
         end
         ACT_SERIAL: begin
            width_in[serial_ch_ff] = serial_width;
            manual_in              = 1'b0;
            serial_ch_in           = (serial_ch_ff == CH_W'(CHANNELS - 1)) ? '0
                                                                      : serial_ch_ff + 1'b1;
            rsp_req_valid_in       = 1'b1;
         end
         ACT_ADC: begin
            if (manual_ff && in_adc_ch_ff < CH_W'(CHANNELS)) begin
               width_in[in_adc_ch_ff] = adc_width;
            end
         end
         default: begin
            width_in = width_ff;
         end
      endcase

      // tick shows the current level, other words the level after the update
      rsp_pins_in = '0;
      if (slot_ff < width_in[active_ff] && active_ff < CH_W'(PINS_W)) begin
         rsp_pins_in = PINS_W'(1) << active_ff;
      end
      rsp_req_ch_in = serial_ch_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_data_ff   <= req_tdata[DATA_W-1:0];
         in_adc_ch_ff <= req_tdata[DATA_W+CH_W-1:DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            width_ff[k] <= WIDTH_RESET;
         end
         active_ff    <= '0;
         slot_ff      <= '0;
         manual_ff    <= 1'b1;
         serial_ch_ff <= '0;
      end else if (advance) begin
         width_ff     <= width_in;
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         manual_ff    <= manual_in;
         serial_ch_ff <= serial_ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pins_ff      <= rsp_pins_in;
         rsp_req_valid_ff <= rsp_req_valid_in;
         rsp_req_ch_ff    <= rsp_req_ch_in;
      end
   end

endmodule

// ----- test/multiplexed_servo_pulse_generator_tb.sv -----
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_generator_tb
// Streams tick, serial byte and ADC sample words into the servo pulse
// generator and checks every response word against a cycle-free model of
// the slot timer, the width store and the serial channel sequencer. Runs a
// directed opening, then random phases under several register settings and
// stall patterns, including one long response-side hold-off.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_generator_tb;
   import msp_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam int SERIAL_SCALE = 15;
   localparam int ADC_OFFSET   = 500;
   localparam int WIDTH_MAX    = 4095;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 103;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [DATA_W-1:0]   data;
      logic [CH_W-1:0]     adc_ch;
   } cmd_word_type;

   typedef struct packed {
      logic [PINS_W-1:0] pins;
      logic              valid;
      logic [CH_W-1:0]   channel;
   } pin_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;     // data[9:0], adc_channel[12:10], zero
   logic [1:0]          req_tuser = '0;     // action[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;          // servo_pins[6:0], request_channel[9:7], zero
   logic [0:0]          rsp_tuser;          // request_valid[0]
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   cmd_word_type        pending_words[$];
   pin_word_type        expected_pins[$];
   int                  sender_idle_pct = 26;
   int                  receiver_idle_pct = 78;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;
   logic                hold_done = 1'b0;
   logic                long_hold_req = 1'b0;

   // model state
   cfg_type             cfg;
   logic [WIDTH_W-1:0]  width_mem [CHANNELS];
   logic [WIDTH_W-1:0]  slot_pos;
   int                  cur_ch;
   logic                adc_enabled;
   int                  next_serial_ch;

   multiplexed_servo_pulse_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [PINS_W-1:0] pin_levels();
      return (slot_pos < width_mem[cur_ch]) ? PINS_W'(1 << cur_ch) : '0;
   endfunction

   function automatic pin_word_type advance_servo(input cmd_word_type w);
      pin_word_type res;
      int           level;
      res.valid = 1'b0;
      if (w.act == ACT_TICK) begin
         res.pins = pin_levels();
         slot_pos = slot_pos + 1'b1;
         if (slot_pos >= cfg.slot_ticks || slot_pos == '0) begin
            slot_pos = '0;
            cur_ch = (cur_ch + 1) % CHANNELS;
         end
      end else begin
         if (w.act == ACT_SERIAL) begin
            level = int'(cfg.center_ticks)
                  + ((int'(w.data[7:0]) - int'(cfg.serial_offset)) * SERIAL_SCALE) / 2;
            if (level < 0) level = 0;
            if (level > WIDTH_MAX) level = WIDTH_MAX;
            width_mem[next_serial_ch] = WIDTH_W'(level);
            adc_enabled = 1'b0;
            next_serial_ch = (next_serial_ch + 1) % CHANNELS;
            res.valid = 1'b1;
         end else if (w.act == ACT_ADC) begin
            if (adc_enabled && w.adc_ch < CHANNELS)
               width_mem[w.adc_ch] = WIDTH_W'(2 * int'(w.data) + ADC_OFFSET);
         end
         res.pins = pin_levels();
      end
      res.channel = CH_W'(next_serial_ch + 1);
      return res;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   // sender
   always @(posedge clock) begin : drive_req
      cmd_word_type queued;
      cmd_word_type taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.act    = req_tuser;
            taken.data   = req_tdata[9:0];
            taken.adc_ch = req_tdata[12:10];
            expected_pins.push_back(advance_servo(taken));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               queued = pending_words.pop_front();
               req_tdata  <= {3'b000, queued.adc_ch, queued.data};
               req_tuser  <= queued.act;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long response-side hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch_rsp
      pin_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pins.size() == 0) begin
               note_error($sformatf("unexpected word: tdata=%h tuser=%b", rsp_tdata, rsp_tuser));
            end else begin
               want = expected_pins.pop_front();
               if (rsp_tdata[6:0] !== want.pins || rsp_tuser[0] !== want.valid
                   || rsp_tdata[9:7] !== want.channel)
                  note_error($sformatf(
                     "mismatch: pins exp %b got %b, valid exp %b got %b, channel exp %0d got %0d",
                     want.pins, rsp_tdata[6:0], want.valid, rsp_tuser[0],
                     want.channel, rsp_tdata[9:7]));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multiplexed_servo_pulse_generator_tb: errors");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // upper bits carry junk, only the register width counts
   task automatic set_config(input logic [WIDTH_W-1:0] slot, input logic [WIDTH_W-1:0] center,
                             input logic [BYTE_W-1:0] offset);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(CSR_SLOT_TICKS, {junk[31:12], slot});
      write_csr(CSR_CENTER_TICKS, {junk[19:0], center});
      write_csr(CSR_SERIAL_OFFSET, {junk[23:0], offset});
      cfg.slot_ticks    = slot;
      cfg.center_ticks  = center;
      cfg.serial_offset = offset;
      @(negedge clock);
   endtask

   task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] data,
                             input logic [CH_W-1:0] adc_ch);
      cmd_word_type w;
      w.act    = act;
      w.data   = data;
      w.adc_ch = adc_ch;
      pending_words.push_back(w);
   endtask

   task automatic queue_random(input int count);
      cmd_word_type w;
      int           pick;
      repeat (count) begin
         pick     = $urandom_range(99);
         w.data   = DATA_W'($urandom);
         w.adc_ch = CH_W'($urandom);
         if (pick < 68) begin
            w.act = ACT_TICK;
         end else if (pick < 88) begin
            w.act = ACT_SERIAL;
            // half the bytes land near the offset for widths near the center
            if ($urandom_range(1) == 1)
               w.data[7:0] = cfg.serial_offset + BYTE_W'($urandom_range(40)) - 8'd20;
         end else if (pick < 97) begin
            w.act = ACT_ADC;
         end else begin
            w.act = ACT_UNKNOWN;
         end
         pending_words.push_back(w);
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_pins.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      logic [WIDTH_W-1:0] slot_pick   [PHASES] = '{12'd2663, 12'd5, 12'd4095, 12'd40, 12'd1,
                                                   12'd13, 12'd0, 12'd3000, 12'd7, 12'd25};
      logic [WIDTH_W-1:0] center_pick [PHASES] = '{12'd2048, 12'd10, 12'd0, 12'd300, 12'd4095,
                                                   12'd1024, 12'd2048, 12'd60, 12'd0, 12'd1500};
      logic [BYTE_W-1:0]  offset_pick [PHASES] = '{8'd0, 8'd255, 8'd128, 8'd37, 8'd200,
                                                   8'd100, 8'd255, 8'd0, 8'd90, 8'd160};
      cfg = {SLOT_RESET, CENTER_RESET, OFFSET_RESET};
      for (int k = 0; k < CHANNELS; k++) width_mem[k] = WIDTH_RESET;
      slot_pos       = '0;
      cur_ch         = 0;
      adc_enabled    = 1'b1;
      next_serial_ch = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: ADC while manual, unknown action, serial extremes, channel wrap
      set_config(SLOT_RESET, CENTER_RESET, OFFSET_RESET);
      queue_word(ACT_TICK, 10'h3FF, 3'd7);
      queue_word(ACT_ADC, 10'd0, 3'd0);
      queue_word(ACT_ADC, 10'd1023, 3'd6);
      queue_word(ACT_ADC, 10'd512, 3'd7);
      queue_word(ACT_ADC, 10'd1000, 3'd3);
      queue_word(ACT_UNKNOWN, 10'h3FF, 3'd7);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      queue_word(ACT_SERIAL, 10'd0, 3'd0);
      queue_word(ACT_SERIAL, 10'd255, 3'd0);
      queue_word(ACT_SERIAL, 10'd1023, 3'd5);
      queue_word(ACT_SERIAL, 10'd101, 3'd0);
      queue_word(ACT_SERIAL, 10'd99, 3'd0);
      queue_word(ACT_ADC, 10'd0, 3'd1);
      queue_word(ACT_SERIAL, 10'd100, 3'd0);
      queue_word(ACT_SERIAL, 10'h2C8, 3'd2);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      wait_drained();

      // zero slot length, width saturating low
      set_config(12'd0, 12'd0, 8'd255);
      queue_word(ACT_SERIAL, 10'd0, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      wait_drained();

      // width saturating high
      set_config(12'd1, 12'd4095, 8'd0);
      queue_word(ACT_SERIAL, 10'd255, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      queue_word(ACT_TICK, 10'd0, 3'd0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 4) begin
            sender_idle_pct   = 26;
            receiver_idle_pct = 78;
         end else if (p < 7) begin
            sender_idle_pct   = 78;
            receiver_idle_pct = 26;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         set_config(slot_pick[p], center_pick[p], offset_pick[p]);
         if (p == 8) long_hold_req = 1'b1;
         queue_random(PHASE_WORDS);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_pins.size() == 0) begin
         $display("multiplexed_servo_pulse_generator_tb: clean");
      end else begin
         $display("multiplexed_servo_pulse_generator_tb: errors");
      end
      $finish;
   end

endmodule
